@@ rtl/bresenham_line_rasterizer_unit_defines.svh @@
// Assertion helpers for the rasterizer RTL.
`ifndef BRESENHAM_LINE_RASTERIZER_UNIT_DEFINES_SVH
`define BRESENHAM_LINE_RASTERIZER_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define BLR_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define BLR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/blr_pkg.sv @@
package blr_pkg;

  typedef enum logic {
    CMD_START   = 1'b0,
    CMD_ADVANCE = 1'b1
  } cmd_e;

  localparam int unsigned QueueDepth = 2;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

@@ rtl/blr_front.sv @@
module blr_front #(
  parameter int unsigned CoordBits = 12,
  parameter int unsigned ColorBits = 8,
  parameter int unsigned EntryBits = 6 * 12 + 7 + 8
) (
  input  logic                 cmd_i,
  input  logic [CoordBits-1:0] start_x_i,
  input  logic [CoordBits-1:0] start_y_i,
  input  logic [CoordBits-1:0] end_x_i,
  input  logic [CoordBits-1:0] end_y_i,
  input  logic [ColorBits-1:0] color_in_i,
  output logic [EntryBits-1:0] entry_o
);
  import blr_pkg::*;

  localparam int unsigned ErrBits = CoordBits + 3;

  typedef struct packed {
    cmd_e                 cmd;
    logic [CoordBits-1:0] sx;
    logic [CoordBits-1:0] sy;
    logic [CoordBits-1:0] major_end;
    logic [CoordBits-1:0] dmaj;
    logic [CoordBits-1:0] dmin;
    logic                 col_neg;
    logic                 row_neg;
    logic                 steep;
    logic [ErrBits-1:0]   err;
    logic [ColorBits-1:0] color;
  } entry_t;

  entry_t               entry;
  logic                 x_up;
  logic                 y_up;
  logic [CoordBits-1:0] adx;
  logic [CoordBits-1:0] ady;
  logic                 steep;

  // Classify the line: step directions, major axis and initial decision term.
  always_comb begin
    x_up  = end_x_i > start_x_i;
    y_up  = end_y_i > start_y_i;
    adx   = x_up ? (end_x_i - start_x_i) : (start_x_i - end_x_i);
    ady   = y_up ? (end_y_i - start_y_i) : (start_y_i - end_y_i);
    steep = ady > adx;

    entry.cmd       = cmd_e'(cmd_i);
    entry.sx        = start_x_i;
    entry.sy        = start_y_i;
    entry.major_end = steep ? end_y_i : end_x_i;
    entry.dmaj      = steep ? ady : adx;
    entry.dmin      = steep ? adx : ady;
    entry.col_neg   = !x_up;
    entry.row_neg   = !y_up;
    entry.steep     = steep;
    entry.err       = ErrBits'({entry.dmin, 1'b0}) - ErrBits'(entry.dmaj);
    entry.color     = color_in_i;
  end

  assign entry_o = entry;

endmodule

@@ rtl/blr_queue.sv @@
module blr_queue #(
  parameter int unsigned Width = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  logic [Width-1:0]   push_data_i,
  input  logic               pop_i,
  output logic [Width-1:0]   pop_data_o,
  output blr_pkg::q_status_t status_o
);
  import blr_pkg::*;

  localparam int unsigned PtrBits   = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CountBits = $clog2(QueueDepth + 1);

  logic [Width-1:0]     mem_q [QueueDepth];
  logic [PtrBits-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PtrBits-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CountBits-1:0] count_q, count_d;
  logic                 do_push;
  logic                 do_pop;

  assign status_o.full  = (count_q == CountBits'(QueueDepth));
  assign status_o.empty = (count_q == '0);
  assign do_push        = push_i && !status_o.full;
  assign do_pop         = pop_i && !status_o.empty;
  assign pop_data_o     = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrBits'(QueueDepth - 1)) ? '0 : wr_ptr_q + PtrBits'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrBits'(QueueDepth - 1)) ? '0 : rd_ptr_q + PtrBits'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CountBits'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CountBits'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

@@ rtl/blr_back.sv @@
module blr_back #(
  parameter int unsigned CoordBits = 12,
  parameter int unsigned ColorBits = 8,
  parameter int unsigned EntryBits = 6 * 12 + 7 + 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 entry_valid_i,
  input  logic [EntryBits-1:0] entry_i,
  output logic                 pop_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [CoordBits-1:0] pixel_x_o,
  output logic [CoordBits-1:0] pixel_y_o,
  output logic [ColorBits-1:0] color_out_o,
  output logic                 last_o
);
  import blr_pkg::*;

  localparam int unsigned ErrBits = CoordBits + 3;

  typedef struct packed {
    cmd_e                 cmd;
    logic [CoordBits-1:0] sx;
    logic [CoordBits-1:0] sy;
    logic [CoordBits-1:0] major_end;
    logic [CoordBits-1:0] dmaj;
    logic [CoordBits-1:0] dmin;
    logic                 col_neg;
    logic                 row_neg;
    logic                 steep;
    logic [ErrBits-1:0]   err;
    logic [ColorBits-1:0] color;
  } entry_t;

  entry_t               entry;
  logic                 busy_q, busy_d;
  logic [CoordBits-1:0] col_q, col_d;
  logic [CoordBits-1:0] row_q, row_d;
  logic [CoordBits-1:0] major_end_q, major_end_d;
  logic [CoordBits-1:0] dmaj_q, dmaj_d;
  logic [CoordBits-1:0] dmin_q, dmin_d;
  logic [ErrBits-1:0]   err_q, err_d;
  logic                 col_neg_q, col_neg_d;
  logic                 row_neg_q, row_neg_d;
  logic                 steep_q, steep_d;
  logic [ColorBits-1:0] color_q, color_d;

  logic                 out_valid_q, out_valid_d;
  logic [CoordBits-1:0] px_q, px_d;
  logic [CoordBits-1:0] py_q, py_d;
  logic [ColorBits-1:0] pc_q, pc_d;
  logic                 plast_q, plast_d;

  logic                 emit;
  logic                 minor_step;
  logic [CoordBits-1:0] col_step;
  logic [CoordBits-1:0] row_step;
  logic [ErrBits-1:0]   err_inc;

  assign entry = entry_i;
  // Take an item only when the output register is free or draining.
  assign pop_o = entry_valid_i && (!out_valid_q || out_ready_i);

  always_comb begin
    busy_d      = busy_q;
    col_d       = col_q;
    row_d       = row_q;
    major_end_d = major_end_q;
    dmaj_d      = dmaj_q;
    dmin_d      = dmin_q;
    err_d       = err_q;
    col_neg_d   = col_neg_q;
    row_neg_d   = row_neg_q;
    steep_d     = steep_q;
    color_d     = color_q;
    emit        = 1'b0;
    px_d        = px_q;
    py_d        = py_q;
    pc_d        = pc_q;
    plast_d     = plast_q;

    minor_step = !err_q[ErrBits-1];
    err_inc    = minor_step ? (ErrBits'({dmin_q, 1'b0}) - ErrBits'({dmaj_q, 1'b0}))
                            : ErrBits'({dmin_q, 1'b0});
    col_step   = col_neg_q ? (col_q - CoordBits'(1)) : (col_q + CoordBits'(1));
    row_step   = row_neg_q ? (row_q - CoordBits'(1)) : (row_q + CoordBits'(1));

    if (pop_o) begin
      unique case (entry.cmd)
        CMD_START: begin
          col_d       = entry.sx;
          row_d       = entry.sy;
          major_end_d = entry.major_end;
          dmaj_d      = entry.dmaj;
          dmin_d      = entry.dmin;
          err_d       = entry.err;
          col_neg_d   = entry.col_neg;
          row_neg_d   = entry.row_neg;
          steep_d     = entry.steep;
          color_d     = entry.color;
          busy_d      = (entry.dmaj != '0);
          emit        = 1'b1;
          px_d        = entry.sx;
          py_d        = entry.sy;
          pc_d        = entry.color;
          plast_d     = (entry.dmaj == '0);
        end
        CMD_ADVANCE: begin
          // Drop advances that arrive with no line in progress.
          if (busy_q) begin
            err_d = err_q + err_inc;
            if (steep_q) begin
              row_d   = row_step;
              col_d   = minor_step ? col_step : col_q;
              plast_d = (row_step == major_end_q);
            end else begin
              col_d   = col_step;
              row_d   = minor_step ? row_step : row_q;
              plast_d = (col_step == major_end_q);
            end
            busy_d = !plast_d;
            emit   = 1'b1;
            px_d   = col_d;
            py_d   = row_d;
            pc_d   = color_q;
          end
        end
        default: begin
        end
      endcase
    end

    if (emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    col_q       <= col_d;
    row_q       <= row_d;
    major_end_q <= major_end_d;
    dmaj_q      <= dmaj_d;
    dmin_q      <= dmin_d;
    err_q       <= err_d;
    col_neg_q   <= col_neg_d;
    row_neg_q   <= row_neg_d;
    steep_q     <= steep_d;
    color_q     <= color_d;
    if (emit) begin
      px_q    <= px_d;
      py_q    <= py_d;
      pc_q    <= pc_d;
      plast_q <= plast_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign pixel_x_o   = px_q;
  assign pixel_y_o   = py_q;
  assign color_out_o = pc_q;
  assign last_o      = plast_q;

endmodule

@@ rtl/bresenham_line_rasterizer_unit.sv @@
// Bresenham line rasterizer. A start item (cmd_i = 0) latches two endpoints
// and a color index and yields the first endpoint as a pixel; each advance
// item (cmd_i = 1) yields the next pixel of the line, and last_o marks the
// second endpoint (a single-point line is flagged last on its start item).
// Advance items with no line in progress produce no pixel, and a start item
// during a line abandons it. The front end classifies an item in the cycle
// of acceptance and writes a two-entry queue; the back end pops one entry
// per clock while its output register is free or draining, through a single
// add of the error term and one coordinate step and compare, so the unit
// sustains one pixel per clock while out_ready_i stays high. out_valid_o is
// registered: an accepted item is written to the queue, then popped into the
// output register. While out_ready_i is low the queue takes up to two more
// items behind the held pixel, and in_ready_o drops once it is full.
`include "bresenham_line_rasterizer_unit_defines.svh"

module bresenham_line_rasterizer_unit #(
  parameter int unsigned COORD_BITS = 12,
  parameter int unsigned COLOR_BITS = 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic                  cmd_i,
  input  logic [COORD_BITS-1:0] start_x_i,
  input  logic [COORD_BITS-1:0] start_y_i,
  input  logic [COORD_BITS-1:0] end_x_i,
  input  logic [COORD_BITS-1:0] end_y_i,
  input  logic [COLOR_BITS-1:0] color_in_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [COORD_BITS-1:0] pixel_x_o,
  output logic [COORD_BITS-1:0] pixel_y_o,
  output logic [COLOR_BITS-1:0] color_out_o,
  output logic                  last_o
);
  import blr_pkg::*;

  // Queue entry: command, endpoints, deltas, step flags, error term, color.
  localparam int unsigned EntryBits = 6 * COORD_BITS + 7 + COLOR_BITS;

  logic [EntryBits-1:0] front_entry;
  logic [EntryBits-1:0] back_entry;
  q_status_t            q_status;
  logic                 back_pop;

  // Front end: classify the item and precompute the line setup.
  blr_front #(
    .CoordBits(COORD_BITS),
    .ColorBits(COLOR_BITS),
    .EntryBits(EntryBits)
  ) u_front (
    .cmd_i     (cmd_i),
    .start_x_i (start_x_i),
    .start_y_i (start_y_i),
    .end_x_i   (end_x_i),
    .end_y_i   (end_y_i),
    .color_in_i(color_in_i),
    .entry_o   (front_entry)
  );

  // Accept whenever the queue has room; the back end stalls on its own.
  assign in_ready_o = !q_status.full;

  blr_queue #(
    .Width(EntryBits)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (in_valid_i),
    .push_data_i(front_entry),
    .pop_i      (back_pop),
    .pop_data_o (back_entry),
    .status_o   (q_status)
  );

  // Back end: hold the line state and step it one pixel per popped advance.
  blr_back #(
    .CoordBits(COORD_BITS),
    .ColorBits(COLOR_BITS),
    .EntryBits(EntryBits)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .entry_valid_i(!q_status.empty),
    .entry_i      (back_entry),
    .pop_o        (back_pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .pixel_x_o    (pixel_x_o),
    .pixel_y_o    (pixel_y_o),
    .color_out_o  (color_out_o),
    .last_o       (last_o)
  );

  // A delivered pixel with nothing popped behind it leaves the output empty.
  `BLR_ASSERT_NEXT(a_out_drains, out_valid_o && out_ready_i && !back_pop,
                   !out_valid_o, "pixel repeated after delivery")
  // No pixel appears without a queued item to produce it.
  `BLR_ASSERT_NEXT(a_no_spurious_pixel, !out_valid_o && q_status.empty,
                   !out_valid_o, "pixel without a queued item")
  // The back end only takes an item while the queue holds one.
  `BLR_ASSERT_IMPL(a_pop_nonempty, back_pop, !q_status.empty, "pop from an empty queue")

endmodule

@@ dv/line_pixel_checker.sv @@
`timescale 1ns / 100ps

// Watches both channels of the line rasterizer, traces the line in step
// with every accepted item, and compares each emitted pixel with the
// oldest pixel owed.
module line_pixel_checker #(
  parameter int unsigned COORD_BITS = 12,
  parameter int unsigned COLOR_BITS = 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  in_ready_i,
  input  logic                  cmd_i,
  input  logic [COORD_BITS-1:0] start_x_i,
  input  logic [COORD_BITS-1:0] start_y_i,
  input  logic [COORD_BITS-1:0] end_x_i,
  input  logic [COORD_BITS-1:0] end_y_i,
  input  logic [COLOR_BITS-1:0] color_in_i,
  input  logic                  out_valid_i,
  input  logic                  out_ready_i,
  input  logic [COORD_BITS-1:0] pixel_x_i,
  input  logic [COORD_BITS-1:0] pixel_y_i,
  input  logic [COLOR_BITS-1:0] color_out_i,
  input  logic                  last_i,
  output int                    mismatches_o,
  output int                    pixels_owed_o
);
  import blr_pkg::*;

  localparam int unsigned ErrBits = COORD_BITS + 3;

  typedef struct packed {
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
    logic [COLOR_BITS-1:0] color;
    logic                  last;
  } pixel_t;

  pixel_t owed_pixels[$];
  int     mismatches;

  // Line tracer state
  logic                      busy_q;
  logic [COORD_BITS-1:0]     col_q, row_q, major_end_q, dmaj_q, dmin_q;
  logic signed [ErrBits-1:0] err_q;
  logic                      col_neg_q, row_neg_q, steep_q;
  logic [COLOR_BITS-1:0]     color_q;

  assign mismatches_o = mismatches;

  function automatic logic [COORD_BITS-1:0] nudge(logic [COORD_BITS-1:0] v, logic neg);
    return neg ? v - 1'b1 : v + 1'b1;
  endfunction

  // Advance the traced line by one item; returns 1 when the item yields a pixel.
  function automatic bit trace_pixel(input cmd_e cmd,
                                     input logic [COORD_BITS-1:0] sx, sy, ex, ey,
                                     input logic [COLOR_BITS-1:0] color,
                                     output pixel_t px);
    logic [COORD_BITS-1:0] adx, ady;
    logic                  minor_step, at_end;
    if (cmd == CMD_START) begin
      adx = (ex > sx) ? ex - sx : sx - ex;
      ady = (ey > sy) ? ey - sy : sy - ey;
      col_neg_q = !(ex > sx);
      row_neg_q = !(ey > sy);
      steep_q   = ady > adx;
      if (steep_q) begin
        dmaj_q = ady;
        dmin_q = adx;
        major_end_q = ey;
      end else begin
        dmaj_q = adx;
        dmin_q = ady;
        major_end_q = ex;
      end
      err_q   = ErrBits'(2 * int'(dmin_q) - int'(dmaj_q));
      col_q   = sx;
      row_q   = sy;
      color_q = color;
      at_end  = (dmaj_q == '0);
      busy_q  = !at_end;
    end else begin
      if (!busy_q) return 0;
      minor_step = (err_q >= 0);
      if (minor_step) err_q = ErrBits'(int'(err_q) + 2 * (int'(dmin_q) - int'(dmaj_q)));
      else            err_q = ErrBits'(int'(err_q) + 2 * int'(dmin_q));
      if (steep_q) begin
        row_q = nudge(row_q, row_neg_q);
        if (minor_step) col_q = nudge(col_q, col_neg_q);
        at_end = (row_q == major_end_q);
      end else begin
        col_q = nudge(col_q, col_neg_q);
        if (minor_step) row_q = nudge(row_q, row_neg_q);
        at_end = (col_q == major_end_q);
      end
      if (at_end) busy_q = 1'b0;
    end
    px = '{x: col_q, y: row_q, color: color_q, last: at_end};
    return 1;
  endfunction

  function automatic void flag(string msg);
    mismatches++;
    if (mismatches <= 10) $display("[%0t] %s", $realtime, msg);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    pixel_t want, got;
    if (!rst_ni) begin
      busy_q <= 1'b0;
      col_q <= '0;
      row_q <= '0;
      major_end_q <= '0;
      dmaj_q <= '0;
      dmin_q <= '0;
      err_q <= '0;
      col_neg_q <= 1'b0;
      row_neg_q <= 1'b0;
      steep_q <= 1'b0;
      color_q <= '0;
      owed_pixels.delete();
      pixels_owed_o <= 0;
    end else begin
      // Match the outgoing pixel first: it belongs to an older item.
      if (out_valid_i && out_ready_i) begin
        got = '{x: pixel_x_i, y: pixel_y_i, color: color_out_i, last: last_i};
        if (owed_pixels.size() == 0) begin
          flag($sformatf("unexpected pixel x=%0d y=%0d color=%0d last=%0d",
                         got.x, got.y, got.color, got.last));
        end else begin
          want = owed_pixels.pop_front();
          if (want.x !== got.x || want.y !== got.y ||
              want.color !== got.color || want.last !== got.last) begin
            flag($sformatf({"pixel mismatch: expected x=%0d y=%0d color=%0d last=%0d,",
                            " got x=%0d y=%0d color=%0d last=%0d"},
                           want.x, want.y, want.color, want.last,
                           got.x, got.y, got.color, got.last));
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        if (trace_pixel(cmd_e'(cmd_i), start_x_i, start_y_i, end_x_i, end_y_i,
                        color_in_i, want)) begin
          owed_pixels.push_back(want);
        end
      end
      pixels_owed_o <= owed_pixels.size();
    end
  end

endmodule

@@ dv/bresenham_line_rasterizer_unit_tb.sv @@
`timescale 1ns / 100ps

module bresenham_line_rasterizer_unit_tb;
  import blr_pkg::*;

  localparam int unsigned CoordBits  = 12;
  localparam int unsigned ColorBits  = 8;
  localparam int          CoordTop   = (1 << CoordBits) - 1;
  localparam int unsigned ItemTarget = 1500;

  // Receiver pacing modes
  typedef enum int unsigned {
    RX_FLOW,
    RX_HALF,
    RX_SPARSE,
    RX_PERIODIC
  } rx_mode_e;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 in_valid_i;
  logic                 in_ready_o;
  logic                 cmd_i;
  logic [CoordBits-1:0] start_x_i, start_y_i, end_x_i, end_y_i;
  logic [ColorBits-1:0] color_in_i;
  logic                 out_valid_o;
  logic                 out_ready_i;
  logic [CoordBits-1:0] pixel_x_o, pixel_y_o;
  logic [ColorBits-1:0] color_out_o;
  logic                 last_o;

  int mismatch_count;
  int pixels_owed;

  // Sender bookkeeping: pixels still due on the open line, items that did
  // real work (advances on an idle block are not counted), burst length left.
  int unsigned pixels_left;
  int unsigned work_items;
  int unsigned burst_left;

  bresenham_line_rasterizer_unit #(
    .COORD_BITS(CoordBits),
    .COLOR_BITS(ColorBits)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .cmd_i      (cmd_i),
    .start_x_i  (start_x_i),
    .start_y_i  (start_y_i),
    .end_x_i    (end_x_i),
    .end_y_i    (end_y_i),
    .color_in_i (color_in_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .pixel_x_o  (pixel_x_o),
    .pixel_y_o  (pixel_y_o),
    .color_out_o(color_out_o),
    .last_o     (last_o)
  );

  line_pixel_checker #(
    .COORD_BITS(CoordBits),
    .COLOR_BITS(ColorBits)
  ) i_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_i   (in_ready_o),
    .cmd_i        (cmd_i),
    .start_x_i    (start_x_i),
    .start_y_i    (start_y_i),
    .end_x_i      (end_x_i),
    .end_y_i      (end_y_i),
    .color_in_i   (color_in_i),
    .out_valid_i  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .pixel_x_i    (pixel_x_o),
    .pixel_y_i    (pixel_y_o),
    .color_out_i  (color_out_o),
    .last_i       (last_o),
    .mismatches_o (mismatch_count),
    .pixels_owed_o(pixels_owed)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Hard stop: far beyond the slowest legal run, even with every receiver stall.
  initial begin
    #5000000;
    $display("Some tests failed");
    $finish;
  end

  // Receiver: switch between pacing modes at random intervals, and
  // hold off completely for a long stretch now and then so the block fills
  // up and has to stall its input while the sender keeps offering items.
  initial begin : receiver
    rx_mode_e    mode;
    int unsigned mode_left, cyc, hold_left;
    out_ready_i = 1'b0;
    mode        = RX_FLOW;
    mode_left   = 0;
    cyc         = 0;
    hold_left   = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      cyc++;
      if (cyc % 1500 == 800) hold_left = 80;
      if (mode_left == 0) begin
        mode      = rx_mode_e'($urandom_range(0, 3));
        mode_left = $urandom_range(30, 300);
      end
      mode_left--;
      if (hold_left != 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        case (mode)
          RX_FLOW:     out_ready_i <= 1'b1;
          RX_HALF:     out_ready_i <= ($urandom_range(0, 1) != 0);
          RX_SPARSE:   out_ready_i <= ($urandom_range(0, 4) == 0);
          default:     out_ready_i <= (cyc % 4 != 0);
        endcase
      end
    end
  end

  // Offer one item and hold it until accepted, then either keep the burst
  // going or drop valid for a random gap.
  task automatic offer(input cmd_e cmd,
                       input logic [CoordBits-1:0] sx, sy, ex, ey,
                       input logic [ColorBits-1:0] color);
    int dx, dy;
    int unsigned gap;
    in_valid_i <= 1'b1;
    cmd_i      <= cmd;
    start_x_i  <= sx;
    start_y_i  <= sy;
    end_x_i    <= ex;
    end_y_i    <= ey;
    color_in_i <= color;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    // Track how many pixels the open line still owes.
    if (cmd == CMD_START) begin
      dx = (ex > sx) ? int'(ex - sx) : int'(sx - ex);
      dy = (ey > sy) ? int'(ey - sy) : int'(sy - ey);
      pixels_left = (dx > dy) ? dx : dy;
      work_items++;
    end else if (pixels_left != 0) begin
      pixels_left--;
      work_items++;
    end
    if (burst_left != 0) begin
      burst_left--;
    end else begin
      gap = $urandom_range(1, 6);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                : $urandom_range(0, 12);
    end
  endtask

  task automatic start_line(input int sx, sy, ex, ey, color);
    offer(CMD_START, CoordBits'(sx), CoordBits'(sy), CoordBits'(ex), CoordBits'(ey),
          ColorBits'(color));
  endtask

  // Advance items carry junk in the endpoint and color fields: the block
  // must ignore them.
  task automatic advance(input int unsigned count);
    repeat (count) begin
      offer(CMD_ADVANCE,
            CoordBits'($urandom_range(0, CoordTop)), CoordBits'($urandom_range(0, CoordTop)),
            CoordBits'($urandom_range(0, CoordTop)), CoordBits'($urandom_range(0, CoordTop)),
            ColorBits'($urandom_range(0, 255)));
    end
  endtask

  // Stop offering until every owed pixel has come out.
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pixels_owed != 0) @(posedge clk_i);
  endtask

  // Edge columns and rows come up often so lines hit both ends of the range.
  function automatic int pick_coord();
    case ($urandom_range(0, 9))
      0:       return 0;
      1:       return CoordTop;
      default: return $urandom_range(0, CoordTop);
    endcase
  endfunction

  function automatic int near(input int base, input int unsigned reach);
    int off, v;
    off = $urandom_range(0, reach);
    if ($urandom_range(0, 1) != 0) off = -off;
    v = base + off;
    if (v < 0 || v > CoordTop) v = base - off;
    return v;
  endfunction

  initial begin : stimulus
    int unsigned kind;
    int          sx, sy;
    in_valid_i  = 1'b0;
    cmd_i       = CMD_START;
    start_x_i   = '0;
    start_y_i   = '0;
    end_x_i     = '0;
    end_y_i     = '0;
    color_in_i  = '0;
    rst_ni      = 1'b0;
    pixels_left = 0;
    work_items  = 0;
    burst_left  = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed lines
    advance(1);                                 // advance with no line open
    start_line(0, 0, 0, 0, 0);                  // single point, origin
    start_line(CoordTop, CoordTop, CoordTop, CoordTop, 255);
    start_line(4093, 7, CoordTop, 7, 90);       // horizontal to the right edge
    advance(2);
    start_line(10, 3, 10, 0, 165);              // vertical, going up
    advance(3);
    start_line(0, CoordTop, 1, 4091, 60);       // steep, going up
    advance(4);
    start_line(CoordTop, 0, 4092, 3, 195);      // equal deltas: column is major
    advance(3);
    start_line(100, 100, 110, 100, 15);         // abandoned by the next start
    advance(1);
    start_line(2048, 2048, 2048, 2048, 240);
    advance(1);                                 // line already done
    drain();

    // Random lines: mostly complete short ones, some longer, some cut off,
    // and a share of loose noise items.
    while (work_items < ItemTarget) begin
      kind = $urandom_range(0, 99);
      if (kind < 75) begin
        sx = pick_coord();
        sy = pick_coord();
        start_line(sx, sy, near(sx, (kind < 65) ? 12 : 60),
                   near(sy, (kind < 65) ? 12 : 60), $urandom_range(0, 255));
        advance(pixels_left);
        if ($urandom_range(0, 9) == 0) advance($urandom_range(1, 2));
      end else if (kind < 88) begin
        start_line(pick_coord(), pick_coord(), pick_coord(), pick_coord(),
                   $urandom_range(0, 255));
        advance($urandom_range(0, 12));
      end else begin
        repeat ($urandom_range(1, 5)) begin
          if ($urandom_range(0, 1) != 0) begin
            start_line(pick_coord(), pick_coord(), pick_coord(), pick_coord(),
                       $urandom_range(0, 255));
          end else begin
            advance(1);
          end
        end
      end
      if ($urandom_range(0, 39) == 0) drain();
    end

    // Let the last pixels out, then keep watching for stray ones.
    drain();
    repeat (20) @(posedge clk_i);
    if (mismatch_count == 0 && pixels_owed == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
